FILE: hdl/chtb_pkg.sv
// ============================================================================
// chtb_pkg: shared types and constants for the cyclic handler timer bank
// Request and result payloads, channel record layout, codes and the
// controller state encoding.
// ============================================================================
package chtb_pkg;

    localparam int CHANNEL_COUNT = 8;
    localparam int IDX_W         = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int CHAN_W        = 8;
    localparam int TIME_W        = 32;

    localparam logic [CHAN_W-1:0] CHANNEL_LIMIT = CHAN_W'(CHANNEL_COUNT);
    localparam logic [IDX_W-1:0]  LAST_IDX      = IDX_W'(CHANNEL_COUNT - 1);

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_CREATE = 2'd1,
        OP_START  = 2'd2,
        OP_STOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_FIRED  = 2'd1,
        KIND_DONE   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_PAR = 2'd1,
        STAT_OBJ = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        CH_NONE      = 2'd0,
        CH_STOP      = 2'd1,
        CH_RUN       = 2'd2,
        CH_RUN_PHASE = 2'd3
    } chst_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_TICK,
        ST_CMD,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t               operation;
        logic [CHAN_W-1:0] channel;
        logic [1:0]        attributes;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] phase;
    } req_t;

    typedef struct packed {
        kind_t             result_kind;
        logic [CHAN_W-1:0] fired_channel;
        stat_t             status;
        logic              last;
    } rsp_t;

    typedef struct packed {
        chst_t             state;
        logic              phase_en;
        logic [TIME_W-1:0] period_reload;
        logic [TIME_W-1:0] phase_reload;
        logic [TIME_W-1:0] period_left;
        logic [TIME_W-1:0] phase_left;
    } rec_t;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic cnt_inc;
        logic tick_wr;
        logic cmd_wr;
        logic out_fire;
        logic out_done;
        logic out_status;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic cnt_last;
        logic fire;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: hdl/chtb_ctrl.sv
// ============================================================================
// chtb_ctrl: request sequencer
// Accepts one request, fetches the addressed channel record, then walks the
// bank for a tick or applies a single command, holding while the result
// register is occupied and a result is due.
// ============================================================================
module chtb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  chtb_pkg::dp_stat_t  dp_stat,
    output chtb_pkg::ctl_cmd_t  ctl_cmd
);
    import chtb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl_cmd    = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl_cmd.capture = 1'b1;
                    state_next      = ST_FETCH;
                end
            end
            ST_FETCH: begin
                ctl_cmd.rd_en = 1'b1;
                state_next    = dp_stat.is_tick ? ST_TICK : ST_CMD;
            end
            ST_TICK: begin
                if (!dp_stat.fire || dp_stat.out_free) begin
                    ctl_cmd.tick_wr  = 1'b1;
                    ctl_cmd.out_fire = dp_stat.fire;
                    if (dp_stat.cnt_last) begin
                        state_next = ST_DONE;
                    end else begin
                        ctl_cmd.cnt_inc = 1'b1;
                        ctl_cmd.rd_en   = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (dp_stat.out_free) begin
                    ctl_cmd.out_done = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_CMD: begin
                if (dp_stat.out_free) begin
                    ctl_cmd.cmd_wr     = 1'b1;
                    ctl_cmd.out_status = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/chtb_datapath.sv
// ============================================================================
// chtb_datapath: channel record store and update logic
// Holds the request, the channel record memory with existence bits, the
// sweep counter, the tick and command update logic and the result register.
// ============================================================================
module chtb_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  chtb_pkg::req_t      s_req,
    input  chtb_pkg::ctl_cmd_t  ctl_cmd,
    output chtb_pkg::dp_stat_t  dp_stat,
    output logic                m_valid,
    input  logic                m_ready,
    output chtb_pkg::rsp_t      m_rsp
);
    import chtb_pkg::*;

    rec_t mem [CHANNEL_COUNT];

    req_t                     req_reg;
    idx_t                     cnt_reg;
    rec_t                     rd_data_reg;
    logic [CHANNEL_COUNT-1:0] exists_reg;
    logic                     m_valid_reg;
    rsp_t                     m_rsp_reg;

    logic  is_tick;
    logic  bad_id;
    idx_t  req_idx;
    idx_t  cur_idx;
    idx_t  rd_addr;
    chst_t cur_state;
    rec_t  tick_rec;
    logic  tick_fire;
    rec_t  cmd_rec;
    logic  cmd_write;
    logic  cmd_create;
    stat_t cmd_stat;
    logic  wr_en;
    rec_t  wr_data;
    logic  out_free;

    assign is_tick  = (req_reg.operation == OP_TICK);
    assign bad_id   = (req_reg.channel >= CHANNEL_LIMIT);
    assign req_idx  = req_reg.channel[IDX_W-1:0];
    assign cur_idx  = is_tick ? cnt_reg : req_idx;
    assign rd_addr  = is_tick ? (ctl_cmd.cnt_inc ? idx_t'(cnt_reg + 1'b1) : cnt_reg)
                              : req_idx;
    assign cur_state = exists_reg[cur_idx] ? rd_data_reg.state : CH_NONE;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        tick_rec  = rd_data_reg;
        tick_fire = 1'b0;
        case (cur_state)
            CH_RUN_PHASE: begin
                if (rd_data_reg.phase_left != '0) begin
                    tick_rec.phase_left = rd_data_reg.phase_left - 1'b1;
                end else begin
                    tick_rec.state = CH_RUN;
                end
            end
            CH_RUN: begin
                if (rd_data_reg.period_left != '0) begin
                    tick_rec.period_left = rd_data_reg.period_left - 1'b1;
                end else begin
                    tick_fire            = 1'b1;
                    tick_rec.period_left = rd_data_reg.period_reload;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        cmd_rec    = rd_data_reg;
        cmd_write  = 1'b0;
        cmd_create = 1'b0;
        cmd_stat   = STAT_OK;
        if (bad_id) begin
            cmd_stat = STAT_PAR;
        end else begin
            unique case (req_reg.operation)
                OP_CREATE: begin
                    if (cur_state != CH_NONE) begin
                        cmd_stat = STAT_OBJ;
                    end else begin
                        cmd_write             = 1'b1;
                        cmd_create            = 1'b1;
                        cmd_rec.phase_en      = req_reg.attributes[1];
                        cmd_rec.period_reload = req_reg.period;
                        cmd_rec.phase_reload  = req_reg.phase;
                        if (req_reg.attributes[0]) begin
                            cmd_rec.state       = req_reg.attributes[1] ? CH_RUN_PHASE
                                                                        : CH_RUN;
                            cmd_rec.period_left = req_reg.period;
                            cmd_rec.phase_left  = req_reg.phase;
                        end else begin
                            cmd_rec.state       = CH_STOP;
                            cmd_rec.period_left = '0;
                            cmd_rec.phase_left  = '0;
                        end
                    end
                end
                OP_START: begin
                    if (cur_state == CH_NONE) begin
                        cmd_stat = STAT_OBJ;
                    end else if (cur_state == CH_STOP) begin
                        cmd_write           = 1'b1;
                        cmd_rec.state       = rd_data_reg.phase_en ? CH_RUN_PHASE : CH_RUN;
                        cmd_rec.period_left = rd_data_reg.period_reload;
                        cmd_rec.phase_left  = rd_data_reg.phase_reload;
                    end
                end
                OP_STOP: begin
                    if (cur_state == CH_RUN || cur_state == CH_RUN_PHASE) begin
                        cmd_write     = 1'b1;
                        cmd_rec.state = CH_STOP;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign wr_en   = ctl_cmd.tick_wr || (ctl_cmd.cmd_wr && cmd_write);
    assign wr_data = is_tick ? tick_rec : cmd_rec;

    always_ff @(posedge aclk) begin
        if (ctl_cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[cur_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_cmd.capture) begin
            req_reg <= s_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            exists_reg <= '0;
        end else begin
            if (ctl_cmd.capture) begin
                cnt_reg <= '0;
            end else if (ctl_cmd.cnt_inc) begin
                cnt_reg <= idx_t'(cnt_reg + 1'b1);
            end
            if (ctl_cmd.cmd_wr && cmd_create) begin
                exists_reg[req_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl_cmd.out_fire || ctl_cmd.out_done || ctl_cmd.out_status) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_cmd.out_fire) begin
            m_rsp_reg <= '{result_kind: KIND_FIRED, fired_channel: CHAN_W'(cnt_reg),
                           status: STAT_OK, last: 1'b0};
        end else if (ctl_cmd.out_done) begin
            m_rsp_reg <= '{result_kind: KIND_DONE, fired_channel: '0,
                           status: STAT_OK, last: 1'b1};
        end else if (ctl_cmd.out_status) begin
            m_rsp_reg <= '{result_kind: KIND_STATUS, fired_channel: '0,
                           status: cmd_stat, last: 1'b1};
        end
    end

    assign dp_stat.is_tick  = is_tick;
    assign dp_stat.cnt_last = (cnt_reg == LAST_IDX);
    assign dp_stat.fire     = tick_fire;
    assign dp_stat.out_free = out_free;

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

endmodule

FILE: hdl/cyclic_handler_timer_bank.sv
// ============================================================================
// cyclic_handler_timer_bank: bank of cyclic timer channels
// Create, start and stop requests give one status result; a tick request
// gives one fired result per expiring channel in ascending order, then done.
// ============================================================================
//  channel   ports                    payload   direction
//  request   s_valid, s_ready, s_req  req_t     in
//  result    m_valid, m_ready, m_rsp  rsp_t     out
//
//  A command passes the fetch state, then the command state registers its
//  status result and updates the record.
//  A tick streams the bank through one record memory read port, one
//  channel per cycle while no fired result is held up, then issues done
//  once the result register is free.
//  One request is in flight at a time; a held result register stalls the
//  sweep only when a further result is due.
//  Reset clears the existence bits, so every channel reads as nonexistent.
// ============================================================================
module cyclic_handler_timer_bank (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  chtb_pkg::req_t   s_req,
    output logic             m_valid,
    input  logic             m_ready,
    output chtb_pkg::rsp_t   m_rsp
);
    import chtb_pkg::*;

    ctl_cmd_t ctl_cmd;
    dp_stat_t dp_stat;

    chtb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .dp_stat (dp_stat),
        .ctl_cmd (ctl_cmd)
    );

    chtb_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_req   (s_req),
        .ctl_cmd (ctl_cmd),
        .dp_stat (dp_stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

endmodule
